// File: design/fcou_pkg.sv
// Package for the fly camera orientation update block: payload structs,
// fixed-point constants, action codes and small arithmetic helpers.
// No dependencies.
`default_nettype none

package fcou_pkg;

  localparam int DEF_TRIG_ITERATIONS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SENS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd2;

  localparam logic [3:0] ACT_FWD       = 4'd0;
  localparam logic [3:0] ACT_BACK      = 4'd1;
  localparam logic [3:0] ACT_LEFT      = 4'd2;
  localparam logic [3:0] ACT_RIGHT     = 4'd3;
  localparam logic [3:0] ACT_PITCH_UP  = 4'd4;
  localparam logic [3:0] ACT_PITCH_DN  = 4'd5;
  localparam logic [3:0] ACT_YAW_LEFT  = 4'd6;
  localparam logic [3:0] ACT_YAW_RIGHT = 4'd7;
  localparam logic [3:0] ACT_MOUSE     = 4'd8;
  localparam logic [3:0] ACT_SET_PITCH = 4'd9;
  localparam logic [3:0] ACT_SET_YAW   = 4'd10;

  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic signed [35:0] PITCH_LIMIT_Q16 = 36'sd102288;
  localparam logic signed [29:0] PI_Q24 = 30'sd52707179;
  localparam logic signed [29:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [29:0] TWO_PI_Q24 = 30'sd105414357;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic [3:0]         action;
    logic [15:0]        delta_seconds;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [19:0] new_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_t;

  // Arctangent of 2^-i in Q3.24 radians.
  function automatic logic signed [29:0] atan_q24(input logic [4:0] i);
    logic signed [29:0] r;
    unique case (i)
      5'd0:  r = 30'sd13176795;
      5'd1:  r = 30'sd7778716;
      5'd2:  r = 30'sd4110060;
      5'd3:  r = 30'sd2086331;
      5'd4:  r = 30'sd1047214;
      5'd5:  r = 30'sd524117;
      5'd6:  r = 30'sd262123;
      5'd7:  r = 30'sd131069;
      5'd8:  r = 30'sd65536;
      5'd9:  r = 30'sd32768;
      5'd10: r = 30'sd16384;
      5'd11: r = 30'sd8192;
      5'd12: r = 30'sd4096;
      5'd13: r = 30'sd2048;
      5'd14: r = 30'sd1024;
      5'd15: r = 30'sd512;
      5'd16: r = 30'sd256;
      5'd17: r = 30'sd128;
      5'd18: r = 30'sd64;
      5'd19: r = 30'sd32;
      default: r = 30'sd0;
    endcase
    return r;
  endfunction

  // Round half up by n bits and clamp to plus or minus one in Q1.14.
  function automatic logic signed [15:0] q14(input logic signed [65:0] v,
                                             input int unsigned n);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< (n - 1))) >>> n;
    if (t > 66'sd16384) return 16'sd16384;
    if (t < -66'sd16384) return -16'sd16384;
    return 16'(t);
  endfunction

  // Saturate to the pitch field range, then apply the optional limit.
  function automatic logic signed [19:0] pitch_sat(input logic signed [35:0] v,
                                                   input logic lim);
    logic signed [35:0] t;
    t = v;
    if (t > 36'sd524287) t = 36'sd524287;
    if (t < -36'sd524288) t = -36'sd524288;
    if (lim) begin
      if (t > PITCH_LIMIT_Q16) t = PITCH_LIMIT_Q16;
      if (t < -PITCH_LIMIT_Q16) t = -PITCH_LIMIT_Q16;
    end
    return 20'(t);
  endfunction

endpackage

`default_nettype wire

// File: design/fly_camera_orientation_update_top.sv
// Top level of the fly camera orientation update block.
// Depends on fcou_pkg for payload types, constants and helpers.
`default_nettype none

// The block holds a first-person camera (position, yaw, pitch and the front,
// right and up vectors) and applies one action per input item, then returns
// the position and the front, right and up vectors as one result item. It
// works on one item at a time: in_stall is high from acceptance until the
// result has been taken. A move item first passes through the velocity and
// position steps and a mouse item through the mouse scaling; an unused
// action code offers the unchanged state without any update. The next item
// can be accepted in the cycle after the result is taken. Every used action
// passes the yaw wrap (a reciprocal multiplication, a multiplication back and
// one correcting subtraction), two passes of a single CORDIC rotator (one for
// yaw, one for pitch) and the vector products; a single shared multiplier
// serves the velocity, the position moves, the mouse scaling, the yaw wrap
// and the vector products. Configuration registers are written through
// cfg_wen, cfg_index and cfg_wdata; for them to take effect for the next
// item, the user must write them while no item is held, as the block
// itself does not enforce it.
module fly_camera_orientation_update_top #(
  parameter int TRIG_ITERATIONS = fcou_pkg::DEF_TRIG_ITERATIONS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [fcou_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcou_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fcou_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fcou_pkg::out_t                   out_data
);
  import fcou_pkg::*;

  localparam int IT_W = $clog2(TRIG_ITERATIONS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(TRIG_ITERATIONS - 1);
  // floor(2^48 / 2pi in Q3.16); the quotient estimate is short by at most one.
  localparam logic signed [32:0] YAW_RECIP_Q48 = 33'sd683564997;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_VEL, S_VEL_W, S_MV, S_MV_W, S_MS_X, S_MS_Y, S_MS_W,
    S_MODI, S_MQ, S_MQW, S_MRW, S_MFIX, S_MODF, S_CINIT, S_CIT, S_CDONE,
    S_F0, S_F2, S_FW, S_U0, S_U1, S_U2, S_U3, S_U4, S_OUT
  } state_t;

  state_t state;

  // Configuration.
  logic [15:0] move_speed;
  logic [15:0] turn_sens;
  logic        limit_pitch;

  // Camera state.
  logic signed [31:0] pos [3];
  logic signed [19:0] yaw;
  logic signed [19:0] pitch;
  logic signed [15:0] fv [3];
  logic signed [15:0] rv [2];
  logic signed [15:0] uv [3];

  // Working registers.
  in_t                itm;
  logic [31:0]        vel;
  logic [1:0]         k;
  logic signed [35:0] yaw_raw;
  logic [31:0]        mod_a;
  logic [19:0]        mod_r;
  logic [18:0]        mod_rem;
  logic               mod_neg;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [29:0] cz;
  logic               cneg;
  logic [IT_W-1:0]    cit;
  logic               cphase;
  logic signed [33:0] cos_y, sin_y, cos_p, sin_p;
  logic signed [65:0] acc;

  // Shared multiplier with a registered product.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic signed [36:0] sens_s;
  assign sens_s = 37'($signed({1'b0, turn_sens}));

  // Move datapath.
  logic signed [15:0] vec_k;
  logic signed [65:0] mv_d, mv_sum;
  logic signed [31:0] mv_new;
  logic               mv_neg;

  always_comb begin
    vec_k = 16'sd0;
    if (itm.action == ACT_FWD || itm.action == ACT_BACK) begin
      unique case (k)
        2'd0:    vec_k = fv[0];
        2'd1:    vec_k = fv[1];
        default: vec_k = fv[2];
      endcase
    end else begin
      unique case (k)
        2'd0:    vec_k = rv[0];
        2'd1:    vec_k = 16'sd0;
        default: vec_k = rv[1];
      endcase
    end
    mv_neg = (itm.action == ACT_BACK) || (itm.action == ACT_LEFT);
    mv_d = (mul_p + 66'sd2097152) >>> 22;
    mv_sum = 66'(pos[k]) + (mv_neg ? -mv_d : mv_d);
    if (mv_sum > 66'sd2147483647) mv_new = 32'h7FFF_FFFF;
    else if (mv_sum < -66'sd2147483648) mv_new = 32'h8000_0000;
    else mv_new = 32'(mv_sum);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state)
      S_VEL: begin
        mul_a = 33'($signed({1'b0, move_speed}));
        mul_b = 33'($signed({1'b0, itm.delta_seconds}));
      end
      S_MV: begin
        mul_a = 33'(vec_k);
        mul_b = $signed({1'b0, vel});
      end
      S_MS_X: begin
        mul_a = 33'(itm.mouse_dx);
        mul_b = 33'(sens_s);
      end
      S_MS_Y: begin
        mul_a = 33'(itm.mouse_dy);
        mul_b = 33'(sens_s);
      end
      S_MQ: begin
        mul_a = $signed({1'b0, mod_a});
        mul_b = YAW_RECIP_Q48;
      end
      S_MQW: begin
        mul_a = 33'($signed({1'b0, mul_p[61:48]}));
        mul_b = 33'($signed({1'b0, TWO_PI_Q16}));
      end
      S_F0: begin
        mul_a = cos_y[32:0];
        mul_b = cos_p[32:0];
      end
      S_F2: begin
        mul_a = sin_y[32:0];
        mul_b = cos_p[32:0];
      end
      S_U0: begin
        mul_a = -(33'(rv[1]));
        mul_b = 33'(fv[1]);
      end
      S_U1: begin
        mul_a = 33'(rv[1]);
        mul_b = 33'(fv[0]);
      end
      S_U2: begin
        mul_a = 33'(rv[0]);
        mul_b = 33'(fv[2]);
      end
      S_U3: begin
        mul_a = 33'(rv[0]);
        mul_b = 33'(fv[1]);
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  // Angle range reduction in front of the CORDIC: wrap into [-pi, pi], then
  // fold into [-pi/2, pi/2] and remember to negate the results.
  logic signed [19:0] c_ang;
  logic signed [29:0] za, z1, z2;
  logic               zneg;

  always_comb begin
    c_ang = cphase ? pitch : yaw;
    za = {{2{c_ang[19]}}, c_ang, 8'd0};
    if (za > PI_Q24) z1 = za - TWO_PI_Q24;
    else if (za < -PI_Q24) z1 = za + TWO_PI_Q24;
    else z1 = za;
    zneg = 1'b0;
    z2 = z1;
    if (z1 > HALF_PI_Q24) begin
      z2 = z1 - PI_Q24;
      zneg = 1'b1;
    end else if (z1 < -HALF_PI_Q24) begin
      z2 = z1 + PI_Q24;
      zneg = 1'b1;
    end
  end

  // One CORDIC rotation step.
  logic signed [33:0] x_sh, y_sh;
  logic signed [29:0] atan_v;

  always_comb begin
    x_sh = cx >>> cit;
    y_sh = cy >>> cit;
    atan_v = atan_q24(5'(cit));
  end

  logic cp_pos;
  assign cp_pos = (cos_p >= 34'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      move_speed  <= 16'd12800;
      turn_sens   <= 16'd131;
      limit_pitch <= 1'b1;
      pos[0]      <= 32'sd0;
      pos[1]      <= 32'sd0;
      pos[2]      <= 32'sd196608;
      yaw         <= 20'sd102944;
      pitch       <= 20'sd0;
      fv[0]       <= 16'sd0;
      fv[1]       <= 16'sd0;
      fv[2]       <= 16'sd16384;
      rv[0]       <= -16'sd16384;
      rv[1]       <= 16'sd0;
      uv[0]       <= 16'sd0;
      uv[1]       <= 16'sd16384;
      uv[2]       <= 16'sd0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_MOVE_SPEED: move_speed  <= cfg_wdata;
          CFG_TURN_SENS:  turn_sens   <= cfg_wdata;
          CFG_LIMIT:      limit_pitch <= cfg_wdata[0];
          default:        ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            itm   <= in_data;
            state <= S_START;
          end
        end
        S_START: begin
          k <= 2'd0;
          unique case (itm.action)
            ACT_FWD, ACT_BACK, ACT_LEFT, ACT_RIGHT: begin
              yaw_raw <= 36'(yaw);
              state   <= S_VEL;
            end
            ACT_MOUSE: state <= S_MS_X;
            ACT_PITCH_UP: begin
              pitch   <= pitch_sat(36'(pitch) + 36'(sens_s), limit_pitch);
              yaw_raw <= 36'(yaw);
              state   <= S_MODI;
            end
            ACT_PITCH_DN: begin
              pitch   <= pitch_sat(36'(pitch) - 36'(sens_s), limit_pitch);
              yaw_raw <= 36'(yaw);
              state   <= S_MODI;
            end
            ACT_YAW_LEFT: begin
              yaw_raw <= 36'(yaw) - 36'(sens_s);
              state   <= S_MODI;
            end
            ACT_YAW_RIGHT: begin
              yaw_raw <= 36'(yaw) + 36'(sens_s);
              state   <= S_MODI;
            end
            ACT_SET_PITCH: begin
              pitch   <= pitch_sat(36'(itm.new_angle), limit_pitch);
              yaw_raw <= 36'(yaw);
              state   <= S_MODI;
            end
            ACT_SET_YAW: begin
              yaw_raw <= 36'(itm.new_angle);
              state   <= S_MODI;
            end
            default: state <= S_OUT;
          endcase
        end
        S_VEL:   state <= S_VEL_W;
        S_VEL_W: begin
          vel   <= mul_p[31:0];
          state <= S_MV;
        end
        S_MV:    state <= S_MV_W;
        S_MV_W: begin
          pos[k] <= mv_new;
          if (k == 2'd2) begin
            state <= S_MODI;
          end else begin
            k     <= k + 2'd1;
            state <= S_MV;
          end
        end
        S_MS_X:  state <= S_MS_Y;
        S_MS_Y: begin
          yaw_raw <= 36'(yaw) + 36'(mul_p);
          state   <= S_MS_W;
        end
        S_MS_W: begin
          pitch <= pitch_sat(36'(pitch) - 36'(mul_p), limit_pitch);
          state <= S_MODI;
        end
        // The raw yaw magnitude stays below 2^32, so the reciprocal estimate
        // of the quotient is exact or one short and a single subtraction of
        // 2pi finishes the remainder.
        S_MODI: begin
          mod_neg <= yaw_raw[35];
          mod_a   <= yaw_raw[35] ? 32'(-yaw_raw) : 32'(yaw_raw);
          state   <= S_MQ;
        end
        S_MQ:    state <= S_MQW;
        S_MQW:   state <= S_MRW;
        S_MRW: begin
          mod_r <= 20'(mod_a - mul_p[31:0]);
          state <= S_MFIX;
        end
        S_MFIX: begin
          mod_rem <= (mod_r >= {1'b0, TWO_PI_Q16}) ? 19'(mod_r - {1'b0, TWO_PI_Q16})
                                                   : mod_r[18:0];
          state   <= S_MODF;
        end
        S_MODF: begin
          yaw    <= (mod_neg && mod_rem != 19'd0) ? $signed({1'b0, TWO_PI_Q16 - mod_rem})
                                                  : $signed({1'b0, mod_rem});
          cphase <= 1'b0;
          state  <= S_CINIT;
        end
        S_CINIT: begin
          cx    <= CORDIC_GAIN_Q30;
          cy    <= 34'sd0;
          cz    <= z2;
          cneg  <= zneg;
          cit   <= '0;
          state <= S_CIT;
        end
        S_CIT: begin
          if (cz >= 30'sd0) begin
            cx <= cx - y_sh;
            cy <= cy + x_sh;
            cz <= cz - atan_v;
          end else begin
            cx <= cx + y_sh;
            cy <= cy - x_sh;
            cz <= cz + atan_v;
          end
          cit <= cit + 1'b1;
          if (cit == IT_LAST) state <= S_CDONE;
        end
        S_CDONE: begin
          if (!cphase) begin
            cos_y  <= cneg ? -cx : cx;
            sin_y  <= cneg ? -cy : cy;
            cphase <= 1'b1;
            state  <= S_CINIT;
          end else begin
            cos_p <= cneg ? -cx : cx;
            sin_p <= cneg ? -cy : cy;
            state <= S_F0;
          end
        end
        S_F0: begin
          fv[1] <= q14(66'(sin_p), 16);
          rv[0] <= cp_pos ? -q14(66'(sin_y), 16) : q14(66'(sin_y), 16);
          rv[1] <= cp_pos ? q14(66'(cos_y), 16) : -q14(66'(cos_y), 16);
          state <= S_F2;
        end
        S_F2: begin
          fv[0] <= q14(mul_p, 46);
          state <= S_FW;
        end
        S_FW: begin
          fv[2] <= q14(mul_p, 46);
          state <= S_U0;
        end
        S_U0:    state <= S_U1;
        S_U1: begin
          uv[0] <= q14(mul_p, 14);
          state <= S_U2;
        end
        S_U2: begin
          acc   <= mul_p;
          state <= S_U3;
        end
        S_U3: begin
          uv[1] <= q14(acc - mul_p, 14);
          state <= S_U4;
        end
        S_U4: begin
          uv[2] <= q14(mul_p, 14);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    out_data.pos_x   = pos[0];
    out_data.pos_y   = pos[1];
    out_data.pos_z   = pos[2];
    out_data.front_x = fv[0];
    out_data.front_y = fv[1];
    out_data.front_z = fv[2];
    out_data.right_x = rv[0];
    out_data.right_z = rv[1];
    out_data.up_x    = uv[0];
    out_data.up_y    = uv[1];
    out_data.up_z    = uv[2];
  end

`ifndef SYNTHESIS
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown in the cycle after acceptance");

  a_yaw_wrapped: assert property (@(posedge clk) disable iff (rst)
    (yaw >= 20'sd0) && (yaw < $signed({1'b0, TWO_PI_Q16})))
    else $error("yaw outside the wrapped range");

  a_front_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fv[0] <= 16'sd16384) && (fv[0] >= -16'sd16384) &&
                  (uv[1] <= 16'sd16384) && (uv[1] >= -16'sd16384))
    else $error("vector component beyond unit range");
`endif

endmodule

`default_nettype wire

// File: tb/sv/fcou_camera_checker.sv
// Checker for the fly camera orientation update block: tracks camera state,
// predicts each result item and compares it with the block's output.
// Depends on fcou_pkg for the payload structs, codes and constants.
`timescale 1ns / 1ps

module fcou_camera_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wen,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_valid,
  input  logic           in_stall,
  input  fcou_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  fcou_pkg::out_t out_data,
  output int             fail_count,
  output int             pending_count,
  output int             result_count
);
  import fcou_pkg::*;

  localparam longint TWO_PI = 411775;
  localparam longint PLIM = 102288;
  localparam longint PI24 = 52707179;
  localparam longint HPI24 = 26353589;
  localparam longint TPI24 = 105414357;
  localparam longint GAIN = 652032874;
  localparam int ITER = DEF_TRIG_ITERATIONS;

  longint atan_tab [20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
    131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  longint speed, sens, lim;
  longint pos [3];
  longint yaw, pitch;
  longint front [3];
  longint rgt [2];
  longint upv [3];
  out_t camera_q [$];

  function automatic longint div_floor(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-v + ((64'sd1 <<< n) - 1)) >>> n);
  endfunction

  function automatic longint round_q(longint v, int n);
    return div_floor(v + (64'sd1 <<< (n - 1)), n);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unit_q14(longint v, int n);
    return clip(round_q(v, n), -16384, 16384);
  endfunction

  function automatic longint wrap_angle(longint v);
    longint r;
    r = v % TWO_PI;
    if (r < 0) r += TWO_PI;
    return r;
  endfunction

  task automatic cordic(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit neg;
    z = ang * 256; x = GAIN; y = 0; neg = 0;
    while (z > PI24) z -= TPI24;
    while (z < -PI24) z += TPI24;
    if (z > HPI24) begin
      z -= PI24; neg = 1;
    end else if (z < -HPI24) begin
      z += PI24; neg = 1;
    end
    for (int i = 0; i < ITER; i++) begin
      if (z >= 0) begin
        nx = x - div_floor(y, i); y = y + div_floor(x, i); z -= atan_tab[i];
      end else begin
        nx = x + div_floor(y, i); y = y - div_floor(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic rebuild_vectors();
    longint cy, sy, cp, sp, sg;
    cordic(yaw, cy, sy);
    cordic(pitch, cp, sp);
    front[0] = unit_q14(cy * cp, 46);
    front[1] = unit_q14(sp, 16);
    front[2] = unit_q14(sy * cp, 46);
    sg = (cp >= 0) ? 1 : -1;
    rgt[0] = -unit_q14(sy, 16) * sg;
    rgt[1] = unit_q14(cy, 16) * sg;
    upv[0] = unit_q14(-rgt[1] * front[1], 14);
    upv[1] = unit_q14(rgt[1] * front[0] - rgt[0] * front[2], 14);
    upv[2] = unit_q14(rgt[0] * front[1], 14);
  endtask

  function automatic longint pitch_bound(longint v);
    v = clip(v, -524288, 524287);
    if (lim != 0) v = clip(v, -PLIM, PLIM);
    return v;
  endfunction

  task automatic translate(input longint vx, vy, vz, input longint sgn, input longint vel);
    longint vec [3];
    vec = '{vx, vy, vz};
    for (int k = 0; k < 3; k++)
      pos[k] = clip(pos[k] + sgn * round_q(vec[k] * vel, 22), -64'sd2147483648, 64'sd2147483647);
  endtask

  task automatic apply_action(input in_t it);
    longint vel, dx, dy, na;
    out_t r;
    vel = speed * longint'(it.delta_seconds);
    dx = it.mouse_dx; dy = it.mouse_dy; na = it.new_angle;
    case (it.action)
      ACT_FWD:       translate(front[0], front[1], front[2], 1, vel);
      ACT_BACK:      translate(front[0], front[1], front[2], -1, vel);
      ACT_LEFT:      translate(rgt[0], 0, rgt[1], -1, vel);
      ACT_RIGHT:     translate(rgt[0], 0, rgt[1], 1, vel);
      ACT_PITCH_UP:  pitch = pitch_bound(pitch + sens);
      ACT_PITCH_DN:  pitch = pitch_bound(pitch - sens);
      ACT_YAW_LEFT:  yaw = wrap_angle(yaw - sens);
      ACT_YAW_RIGHT: yaw = wrap_angle(yaw + sens);
      ACT_MOUSE: begin
        yaw = wrap_angle(yaw + dx * sens);
        pitch = pitch_bound(pitch - dy * sens);
      end
      ACT_SET_PITCH: pitch = pitch_bound(na);
      ACT_SET_YAW:   yaw = wrap_angle(na);
      default: ;
    endcase
    if (it.action <= ACT_SET_YAW) rebuild_vectors();
    r.pos_x = 32'(pos[0]); r.pos_y = 32'(pos[1]); r.pos_z = 32'(pos[2]);
    r.front_x = 16'(front[0]); r.front_y = 16'(front[1]); r.front_z = 16'(front[2]);
    r.right_x = 16'(rgt[0]); r.right_z = 16'(rgt[1]);
    r.up_x = 16'(upv[0]); r.up_y = 16'(upv[1]); r.up_z = 16'(upv[2]);
    camera_q.push_back(r);
  endtask

  assign pending_count = camera_q.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      speed = 12800; sens = 131; lim = 1;
      pos = '{0, 0, 196608};
      yaw = 102944; pitch = 0;
      front = '{0, 0, 16384};
      rgt = '{-16384, 0};
      upv = '{0, 16384, 0};
      camera_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_MOVE_SPEED: speed = longint'(cfg_wdata);
          CFG_TURN_SENS:  sens = longint'(cfg_wdata);
          CFG_LIMIT:      lim = longint'(cfg_wdata[0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_action(in_data);
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (camera_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = camera_q.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %p", $time, want);
            $display("%0t:          actual   %p", $time, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/tb_fly_camera_orientation_update_top.sv
// Testbench top for the fly camera orientation update block: drives directed
// and random action items and configuration, and reports the verdict.
// Depends on fcou_pkg, fly_camera_orientation_update_top and fcou_camera_checker.
`timescale 1ns / 1ps

module tb_fly_camera_orientation_update_top;
  import fcou_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wen = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int fail_count, pending_count, result_count;

  // Idle and stall rates, in percent, for the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #6 clk = ~clk;

  fly_camera_orientation_update_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  fcou_camera_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  // The receiver stalls at random, decided anew at each edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Present one item, with a random idle gap first, and hold it until accepted.
  // Valid stays high after acceptance so that items can follow back to back;
  // a gap or wait_empty drops it.
  task automatic send_item(input in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_action(input logic [3:0] act, input logic [15:0] dt,
                             input logic [15:0] dx, input logic [15:0] dy,
                             input logic [19:0] ang);
    in_t it;
    it.action = act; it.delta_seconds = dt;
    it.mouse_dx = dx; it.mouse_dy = dy; it.new_angle = ang;
    send_item(it);
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic wait_empty();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // The block is idle once the last result is taken; a few spare cycles
  // separate the phases.
  task automatic drain();
    wait_empty();
    repeat (10) @(posedge clk);
  endtask

  // Registers may only change while the block holds no item.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 0;
    @(posedge clk);
  endtask

  // Random item: mostly real actions with random content; sometimes the
  // unused codes, and angles near the interesting edges.
  task automatic send_random();
    in_t it;
    int pick;
    it = in_t'({$urandom, $urandom, 8'($urandom)});
    pick = $urandom_range(99);
    if (pick < 92) it.action = 4'($urandom_range(10));
    else if (pick < 96) it.action = 4'($urandom_range(15, 11));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(5))
        0: it.new_angle = 20'sd102288 + $signed(20'($urandom_range(4))) - 20'sd2;
        1: it.new_angle = -20'sd102288 + $signed(20'($urandom_range(4))) - 20'sd2;
        2: it.new_angle = 20'sd411775 + $signed(20'($urandom_range(4))) - 20'sd2;
        3: it.new_angle = 20'sd102944 + $signed(20'($urandom_range(4))) - 20'sd2;
        4: it.new_angle = $signed(20'($urandom_range(8))) - 20'sd4;
        default: it.new_angle = 20'sd205887 + $signed(20'($urandom_range(4))) - 20'sd2;
      endcase
    end
    if ($urandom_range(3) == 0) begin
      it.mouse_dx = $signed(16'($urandom_range(64))) - 16'sd32;
      it.mouse_dy = $signed(16'($urandom_range(64))) - 16'sd32;
    end
    send_item(it);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: every action, field extremes, pitch saturation and limit,
    // yaw wrapping both ways, and the unused codes.
    send_action(ACT_FWD, 16'hFFFF, 0, 0, 0);
    send_action(ACT_BACK, 16'h0000, 0, 0, 0);
    send_action(ACT_LEFT, 16'h8000, 0, 0, 0);
    send_action(ACT_RIGHT, 16'h0001, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_action(ACT_PITCH_UP, 0, 0, 0, 0);
    send_action(ACT_PITCH_DN, 0, 0, 0, 0);
    send_action(ACT_YAW_LEFT, 0, 0, 0, 0);
    send_action(ACT_YAW_RIGHT, 0, 0, 0, 0);
    send_action(ACT_MOUSE, 0, 16'h7FFF, 16'h8000, 0);
    send_action(ACT_MOUSE, 0, 16'h8000, 16'h7FFF, 0);
    send_action(ACT_SET_PITCH, 0, 0, 0, 20'h7FFFF);
    send_action(ACT_SET_PITCH, 0, 0, 0, 20'h80000);
    send_action(ACT_SET_YAW, 0, 0, 0, 20'h80000);
    send_action(ACT_SET_YAW, 0, 0, 0, 20'h7FFFF);
    send_action(ACT_SET_YAW, 0, 0, 0, 20'd0);
    send_action(ACT_YAW_LEFT, 0, 0, 0, 0);
    send_action(4'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_action(4'd15, 0, 0, 0, 0);
    drain();

    // Limit off: pitch runs to the field range, through a vertical view.
    write_reg(CFG_LIMIT, 16'd0);
    write_reg(CFG_TURN_SENS, 16'hFFFF);
    write_reg(CFG_MOVE_SPEED, 16'hFFFF);
    send_action(ACT_SET_PITCH, 0, 0, 0, 20'd102944);
    send_action(ACT_FWD, 16'hFFFF, 0, 0, 0);
    send_action(ACT_SET_PITCH, 0, 0, 0, 20'd205887);
    send_action(ACT_RIGHT, 16'hFFFF, 0, 0, 0);
    send_action(ACT_MOUSE, 0, 16'h8000, 16'h8000, 0);
    send_action(ACT_PITCH_UP, 0, 0, 0, 0);
    send_action(ACT_MOUSE, 0, 16'h7FFF, 16'h7FFF, 0);
    send_action(ACT_PITCH_DN, 0, 0, 0, 0);
    drain();

    // Random phases across several register settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_MOVE_SPEED, 16'd12800); write_reg(CFG_TURN_SENS, 16'd131);
          write_reg(CFG_LIMIT, 16'd1);
        end
        1: begin
          write_reg(CFG_MOVE_SPEED, 16'd0); write_reg(CFG_TURN_SENS, 16'd0);
        end
        2: begin
          write_reg(CFG_MOVE_SPEED, 16'hFFFF); write_reg(CFG_TURN_SENS, 16'd4000);
          write_reg(CFG_LIMIT, 16'd0);
        end
        3: begin
          write_reg(CFG_TURN_SENS, 16'hFFFF); write_reg(CFG_LIMIT, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_MOVE_SPEED, 16'($urandom)); write_reg(CFG_TURN_SENS, 16'($urandom));
          write_reg(CFG_LIMIT, 16'($urandom));
        end
      endcase
      for (int n = 0; n < 190; n++) begin
        send_random();
        // Now and then let the block empty completely before going on.
        if (n == 95) wait_empty();
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    $display("Covered all eleven actions and unused codes, four register settings plus random");
    $display("ones, and idle or stall phases on both sides; %0d result items checked.",
             result_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Slowest run: about 1550 items, plus receiver stalls and sender gaps.
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// File: filelist.f
design/fcou_pkg.sv
design/fly_camera_orientation_update_top.sv
tb/sv/fcou_camera_checker.sv
tb/sv/tb_fly_camera_orientation_update_top.sv
